// ===== sv/arng_pkg.sv =====
// shared types and constants for the address range table
`timescale 1ns / 1ps
package arng_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_FIND   = 3'd2;
	localparam logic [2:0] OP_PRED   = 3'd3;
	localparam logic [2:0] OP_SUCC   = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REPLACED  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [63:0] addr;
		logic [31:0] range_size;
		logic [15:0] handle;
	} arng_req_t;

	typedef struct packed {
		logic        hit;
		logic [63:0] entry_start;
		logic [31:0] entry_length;
		logic [15:0] entry_tag;
		logic [1:0]  status;
	} arng_rsp_t;

	typedef enum logic [2:0] {
		K_INSERT = 3'd0,
		K_REMOVE = 3'd1,
		K_FIND   = 3'd2,
		K_PRED   = 3'd3,
		K_SUCC   = 3'd4,
		K_CLEAR  = 3'd5,
		K_BAD    = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] addr;
		logic [31:0] size;
		logic [15:0] tag;
	} arng_item_t;

	typedef struct packed {
		logic           valid;
		arng_item_t     item;
	} arng_q_out_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             idle;
	} arng_stat_t;

endpackage

// ===== sv/arng_front.sv =====
// front end: accepts request beats, classifies the opcode, two-entry queue
`timescale 1ns / 1ps
module arng_front import arng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  arng_req_t   req,
	output arng_q_out_t head,
	input  logic        pop
);

	arng_item_t slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	arng_item_t item_in;
	logic       push;
	logic       do_pop;

	always_comb begin
		item_in.addr = req.addr;
		item_in.size = req.range_size;
		item_in.tag  = req.handle;
		unique case (req.opcode)
			OP_INSERT: item_in.kind = K_INSERT;
			OP_REMOVE: item_in.kind = K_REMOVE;
			OP_FIND:   item_in.kind = K_FIND;
			OP_PRED:   item_in.kind = K_PRED;
			OP_SUCC:   item_in.kind = K_SUCC;
			OP_CLEAR:  item_in.kind = K_CLEAR;
			default:   item_in.kind = K_BAD;
		endcase
	end

	assign req_stall  = (fill_q == 2'd2);
	assign push       = req_valid && !req_stall;
	assign do_pop     = pop && (fill_q != 2'd0);
	assign head.valid = (fill_q != 2'd0);
	assign head.item  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== sv/arng_back.sv =====
// back end: sorted cell chain, compare, shift, select and result register
`timescale 1ns / 1ps
module arng_back import arng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  arng_q_out_t head,
	output logic        pop,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output arng_rsp_t   rsp,
	output arng_stat_t  stat
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_SEL  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t           state_q;
	arng_item_t       cur_q;
	logic [CNT_W-1:0] count_q;
	logic [63:0]      start_q  [CAPACITY];
	logic [31:0]      length_q [CAPACITY];
	logic [15:0]      tag_q    [CAPACITY];

	logic [CAPACITY-1:0] lt_s1;
	logic [CAPACITY-1:0] le_s1;

	logic        hit_s2;
	logic        with_s2;
	logic [1:0]  status_s2;
	logic [63:0] sel_start_s2;
	logic [31:0] sel_len_s2;
	logic [15:0] sel_tag_s2;

	logic        rsp_valid_q;
	arng_rsp_t   rsp_q;

	logic [CAPACITY-1:0] vvec, at_pos, match, last_le, sel_vec;
	logic                found, any_le, succ_hit, full;
	logic [63:0]         sel_start;
	logic [31:0]         sel_len;
	logic [15:0]         sel_tag;
	logic [63:0]         off;
	logic                in_range;
	logic                out_free;
	logic                fin_go;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign fin_go   = (state_q == S_FIN) && out_free;
	assign pop      = head.valid && ((state_q == S_IDLE) || fin_go);
	assign full     = (count_q == CNT_W'(CAPACITY));

	// per-cell boundary flags from the registered compares
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			vvec[i]    = (CNT_W'(i) < count_q);
			at_pos[i]  = !lt_s1[i] && ((i == 0) ? 1'b1 : lt_s1[(i == 0) ? 0 : i - 1]);
			match[i]   = at_pos[i] && vvec[i] && le_s1[i];
			last_le[i] = le_s1[i] &&
				!((i == CAPACITY - 1) ? 1'b0 : le_s1[(i == CAPACITY - 1) ? i : i + 1]);
		end
		found    = |match;
		any_le   = |le_s1;
		succ_hit = |(at_pos & vvec);
		sel_vec  = (cur_q.kind == K_SUCC) ? (at_pos & vvec) : last_le;
		sel_start = '0;
		sel_len   = '0;
		sel_tag   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_start = sel_start | ({64{sel_vec[i]}} & start_q[i]);
			sel_len   = sel_len   | ({32{sel_vec[i]}} & length_q[i]);
			sel_tag   = sel_tag   | ({16{sel_vec[i]}} & tag_q[i]);
		end
	end

	// containment test on the selected entry
	always_comb begin
		off      = cur_q.addr - sel_start_s2;
		in_range = (sel_len_s2 == 32'd0) ? (off == 64'd0) : (off < {32'd0, sel_len_s2});
	end

	// cell storage: compare stage and shift or write in the select stage
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.item;
		end
		if (state_q == S_CMP) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_s1[i] <= (CNT_W'(i) < count_q) && (start_q[i] <  cur_q.addr);
				le_s1[i] <= (CNT_W'(i) < count_q) && (start_q[i] <= cur_q.addr);
			end
		end
		if (state_q == S_SEL) begin
			sel_start_s2 <= sel_start;
			sel_len_s2   <= sel_len;
			sel_tag_s2   <= sel_tag;
			if (cur_q.kind == K_INSERT) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (found) begin
						if (match[i]) begin
							tag_q[i] <= cur_q.tag;
						end
					end else if (!full) begin
						if (at_pos[i]) begin
							start_q[i]  <= cur_q.addr;
							length_q[i] <= cur_q.size;
							tag_q[i]    <= cur_q.tag;
						end else if (!lt_s1[i] && i > 0) begin
							start_q[i]  <= start_q[(i == 0) ? 0 : i - 1];
							length_q[i] <= length_q[(i == 0) ? 0 : i - 1];
							tag_q[i]    <= tag_q[(i == 0) ? 0 : i - 1];
						end
					end
				end
			end else if (cur_q.kind == K_REMOVE && found) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (!lt_s1[i]) begin
						start_q[i]  <= start_q[i + 1];
						length_q[i] <= length_q[i + 1];
						tag_q[i]    <= tag_q[i + 1];
					end
				end
			end
		end
	end

	// result of the select stage, before the containment check
	always_ff @(posedge clk) begin
		if (state_q == S_SEL) begin
			case (cur_q.kind) inside
				K_INSERT: begin
					hit_s2    <= found || !full;
					with_s2   <= 1'b0;
					status_s2 <= found ? ST_REPLACED : (full ? ST_FULL : ST_OK);
				end
				K_REMOVE: begin
					hit_s2    <= found;
					with_s2   <= 1'b0;
					status_s2 <= found ? ST_OK : ST_NOT_FOUND;
				end
				K_FIND, K_PRED: begin
					hit_s2    <= any_le;
					with_s2   <= any_le;
					status_s2 <= any_le ? ST_OK : ST_NOT_FOUND;
				end
				K_SUCC: begin
					hit_s2    <= succ_hit;
					with_s2   <= succ_hit;
					status_s2 <= succ_hit ? ST_OK : ST_NOT_FOUND;
				end
				K_CLEAR: begin
					hit_s2    <= 1'b1;
					with_s2   <= 1'b0;
					status_s2 <= ST_OK;
				end
				default: begin
					hit_s2    <= 1'b0;
					with_s2   <= 1'b0;
					status_s2 <= ST_NOT_FOUND;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (with_s2 && (cur_q.kind != K_FIND || in_range)) begin
				rsp_q.hit          <= 1'b1;
				rsp_q.entry_start  <= sel_start_s2;
				rsp_q.entry_length <= sel_len_s2;
				rsp_q.entry_tag    <= sel_tag_s2;
				rsp_q.status       <= ST_OK;
			end else begin
				rsp_q.hit          <= hit_s2 && !with_s2;
				rsp_q.entry_start  <= '0;
				rsp_q.entry_length <= '0;
				rsp_q.entry_tag    <= '0;
				rsp_q.status       <= with_s2 ? ST_NOT_FOUND : status_s2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == S_SEL) begin
				if (cur_q.kind == K_INSERT && !found && !full) begin
					count_q <= count_q + CNT_W'(1);
				end else if (cur_q.kind == K_REMOVE && found) begin
					count_q <= count_q - CNT_W'(1);
				end else if (cur_q.kind == K_CLEAR) begin
					count_q <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: if (pop) state_q <= S_CMP;
				S_CMP:  state_q <= S_SEL;
				S_SEL:  state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= pop ? S_CMP : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;
	assign stat.count = count_q;
	assign stat.idle  = (state_q == S_IDLE);

endmodule

// ===== sv/address_range_table.sv =====
// top level of the ordered address range table
`timescale 1ns / 1ps
// channel | valid     | stall     | beat
// request | req_valid | req_stall | req (opcode, addr, range_size, handle)
// result  | rsp_valid | rsp_stall | rsp (hit, entry_start, entry_length, entry_tag, status)
//
// one result beat per request beat, in order
// back end works through each item in order: compare, shift/select, containment check,
// and can take the next item as it finishes the last unless the result side stalls
// reset clears the entry count and the handshake state; cell contents are not reset
// a two-entry queue lets requests land while the back end or the result side stalls
// the result register lets the next item finish while rsp_stall is low
module address_range_table import arng_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  arng_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output arng_rsp_t rsp
);

	arng_q_out_t head;
	logic        pop;
	arng_stat_t  stat;

	// classification and queueing of request beats
	arng_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.head      (head),
		.pop       (pop)
	);

	// sorted cell chain and result register
	arng_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	// entry count never runs past the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// a hit always reports ok or replaced
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> (rsp.status == ST_OK || rsp.status == ST_REPLACED))
		else $error("hit with failing status");

	// a full table report only comes with a full count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) && rsp.status == ST_FULL |-> stat.count == CNT_W'(CAPACITY))
		else $error("table full reported below capacity");

	// an idle back end takes a waiting item at once
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stat.idle && head.valid |-> pop)
		else $error("idle back end left an item waiting");
`endif

endmodule

// ===== verif/address_range_table_tb.sv =====
// self-checking testbench for the ordered address range table
`timescale 1ns / 1ps
module address_range_table_tb;
	import arng_pkg::*;

	// scoreboard: keeps its own sorted copy of the table and a queue of predicted result beats
	class range_table_board;
		logic [63:0] starts[$];
		logic [31:0] lengths[$];
		logic [15:0] tags[$];
		arng_rsp_t pending[$];
		int errors;
		int checked;

		function arng_rsp_t miss_rsp(logic [1:0] st);
			arng_rsp_t r;
			r = '0;
			r.status = st;
			return r;
		endfunction

		function arng_rsp_t entry_rsp(int idx);
			arng_rsp_t r;
			r = '0;
			r.hit = 1'b1;
			r.entry_start = starts[idx];
			r.entry_length = lengths[idx];
			r.entry_tag = tags[idx];
			r.status = ST_OK;
			return r;
		endfunction

		// number of entries below a, or at or below a when include_equal is clear
		function int first_not_below(logic [63:0] a, bit include_equal);
			int n;
			n = 0;
			foreach (starts[i])
				if (starts[i] < a || (!include_equal && starts[i] == a))
					n++;
			return n;
		endfunction

		function void note_request(arng_req_t q);
			arng_rsp_t r;
			int pos;
			logic [63:0] off;
			bit inside_rng;
			r = miss_rsp(ST_NOT_FOUND);
			case (q.opcode)
				OP_INSERT: begin
					pos = first_not_below(q.addr, 1);
					if (pos < starts.size() && starts[pos] == q.addr) begin
						tags[pos] = q.handle;
						r.hit = 1'b1;
						r.status = ST_REPLACED;
					end else if (starts.size() >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						starts.insert(pos, q.addr);
						lengths.insert(pos, q.range_size);
						tags.insert(pos, q.handle);
						r.hit = 1'b1;
						r.status = ST_OK;
					end
				end
				OP_REMOVE: begin
					pos = first_not_below(q.addr, 1);
					if (pos < starts.size() && starts[pos] == q.addr) begin
						starts.delete(pos);
						lengths.delete(pos);
						tags.delete(pos);
						r.hit = 1'b1;
						r.status = ST_OK;
					end
				end
				OP_FIND, OP_PRED: begin
					pos = first_not_below(q.addr, 0) - 1;
					if (pos >= 0) begin
						off = q.addr - starts[pos];
						inside_rng = (lengths[pos] == 0) ? (off == 0)
							: (off < {32'd0, lengths[pos]});
						if (q.opcode == OP_PRED || inside_rng)
							r = entry_rsp(pos);
					end
				end
				OP_SUCC: begin
					pos = first_not_below(q.addr, 1);
					if (pos < starts.size())
						r = entry_rsp(pos);
				end
				OP_CLEAR: begin
					starts.delete();
					lengths.delete();
					tags.delete();
					r.hit = 1'b1;
					r.status = ST_OK;
				end
				default: ;
			endcase
			pending = {pending, r};
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			if (errors <= 40)
				$display("mismatch %0s: got %h want %h (beat %0d)", what, got, want, checked);
		endtask

		task check_result(arng_rsp_t got);
			arng_rsp_t want;
			if (pending.size() == 0) begin
				report("unexpected beat", 64'd1, 64'd0);
				return;
			end
			want = pending.pop_front();
			if (got.hit !== want.hit)
				report("hit", 64'(got.hit), 64'(want.hit));
			if (got.entry_start !== want.entry_start)
				report("entry_start", got.entry_start, want.entry_start);
			if (got.entry_length !== want.entry_length)
				report("entry_length", 64'(got.entry_length), 64'(want.entry_length));
			if (got.entry_tag !== want.entry_tag)
				report("entry_tag", 64'(got.entry_tag), 64'(want.entry_tag));
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
			checked++;
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	arng_req_t req;
	logic rsp_valid;
	logic rsp_stall;
	arng_rsp_t rsp;

	range_table_board board;
	int sent;
	bit hold_results;     // long receiver hold-off request
	bit rsp_noidle;       // stretches with no result-side stalls
	logic [63:0] used_starts[$];

	address_range_table uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hard limit on run time
	initial begin
		#20ms;
		$display("timeout with %0d results pending", board.pending.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// result side: a drawn wait before each beat, a long hold-off on request,
	// check every accepted beat
	initial begin
		int waitc;
		rsp_stall = 1'b1;
		waitc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				board.check_result(rsp);
				waitc = rsp_noidle ? 0 : $urandom_range(0, 9);
			end
			if (hold_results) begin
				rsp_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_results = 1'b0;
				rsp_stall <= 1'b0;
			end else if (waitc > 0) begin
				rsp_stall <= 1'b1;
				waitc--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// drive one request beat, with a random gap before it
	task automatic send_beat(arng_req_t q, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 9);
		if ($urandom_range(0, 1) == 0)
			gap = 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= q;
		do
			@(posedge clk);
		while (req_stall);
		board.note_request(q);
		sent++;
	endtask

	task automatic send_op(logic [2:0] op, logic [63:0] a, logic [31:0] sz, logic [15:0] h);
		arng_req_t q;
		q.opcode = op;
		q.addr = a;
		q.range_size = sz;
		q.handle = h;
		send_beat(q, 1'b0);
	endtask

	// wait until every predicted result has been checked
	task automatic drain();
		req_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// address near a known start so lookups and removes mostly land on real entries
	function automatic logic [63:0] near_addr();
		logic [63:0] base;
		if (used_starts.size() == 0 || $urandom_range(0, 7) == 0)
			return rand64();
		base = used_starts[$urandom_range(0, used_starts.size() - 1)];
		case ($urandom_range(0, 3))
			0: return base;
			1: return base + 64'($urandom_range(0, 300));
			2: return base - 64'($urandom_range(1, 50));
			default: return base + 64'($urandom_range(0, 4096));
		endcase
	endfunction

	task automatic random_op();
		logic [2:0] op;
		logic [63:0] a;
		logic [31:0] sz;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 38) op = OP_INSERT;
		else if (pick < 52) op = OP_REMOVE;
		else if (pick < 72) op = OP_FIND;
		else if (pick < 83) op = OP_PRED;
		else if (pick < 94) op = OP_SUCC;
		else if (pick < 96) op = OP_CLEAR;
		else op = 3'($urandom_range(6, 7));
		a = near_addr();
		case ($urandom_range(0, 4))
			0: sz = 32'd0;
			1: sz = $urandom();
			default: sz = $urandom_range(1, 512);
		endcase
		if (op == OP_INSERT && $urandom_range(0, 2) != 0) begin
			// fresh start on a sparse grid keeps the table busy without many repeats
			a = {$urandom_range(0, 3) == 0 ? $urandom() : 32'd0, $urandom() & 32'hffff_f000};
			used_starts = {used_starts, a};
			if (used_starts.size() > 200)
				void'(used_starts.pop_front());
		end
		send_op(op, a, sz, 16'($urandom()));
	endtask

	initial begin
		arng_req_t q;
		board = new();
		sent = 0;
		hold_results = 1'b0;
		rsp_noidle = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table lookups, field extremes, every opcode and corner
		send_op(OP_FIND, 64'd0, 32'd0, 16'd0);
		send_op(OP_PRED, '1, 32'd0, 16'd0);
		send_op(OP_SUCC, 64'd0, 32'd0, 16'd0);
		send_op(OP_REMOVE, 64'h1000, 32'd0, 16'd0);
		send_op(OP_INSERT, 64'd0, 32'd0, 16'h0000);
		send_op(OP_INSERT, '1, '1, '1);
		send_op(OP_INSERT, 64'hffff_ffff_0000_0000, '1, 16'h5a5a);
		send_op(OP_INSERT, 64'h1000, 32'h10, 16'ha5a5);
		send_op(OP_INSERT, 64'h1000, 32'h999, 16'h1234); // same start: tag swap only
		send_op(OP_FIND, 64'h100f, 32'd0, 16'd0);        // last byte inside
		send_op(OP_FIND, 64'h1010, 32'd0, 16'd0);        // one past the end
		send_op(OP_FIND, 64'd0, 32'd0, 16'd0);           // zero length, own start
		send_op(OP_FIND, 64'd1, 32'd0, 16'd0);           // zero length, just after
		send_op(OP_FIND, '1, 32'd0, 16'd0);              // top of the address space
		send_op(OP_FIND, 64'hffff_ffff_ffff_fffe, 32'd0, 16'd0);
		send_op(OP_PRED, 64'h0fff, 32'd0, 16'd0);
		send_op(OP_SUCC, 64'h1001, 32'd0, 16'd0);
		send_op(OP_SUCC, '1, 32'd0, 16'd0);
		send_op(3'd6, '1, '1, '1);
		send_op(3'd7, 64'd0, 32'd0, 16'd0);
		send_op(OP_REMOVE, 64'h1000, 32'd0, 16'd0);
		send_op(OP_REMOVE, 64'h1000, 32'd0, 16'd0);
		send_op(OP_CLEAR, '1, '1, '1);
		send_op(OP_PRED, '1, 32'd0, 16'd0);

		// fill past capacity with back-to-back beats, receiver held off so the input backs up
		hold_results = 1'b1;
		for (int i = 0; i < CAPACITY + 4; i++) begin
			q.opcode = OP_INSERT;
			q.addr = 64'(i) * 64'h100 + 64'h4000;
			q.range_size = 32'h80;
			q.handle = 16'(i);
			send_beat(q, 1'b1);
		end
		// sender pauses until everything is back
		drain();
		send_op(OP_INSERT, 64'h4000, 32'd1, 16'hbeef); // replace still works when full
		send_op(OP_SUCC, 64'h4001, 32'd0, 16'd0);
		send_op(OP_CLEAR, 64'd0, 32'd0, 16'd0);

		// random traffic, with a clear now and then and a stretch with no result stalls
		while (sent < 1450) begin
			rsp_noidle = (sent > 700 && sent < 850);
			random_op();
		end
		drain();

		$display("covered %0d request beats, %0d result beats checked,", sent, board.checked);
		$display("including a full table, long result hold-off and all opcodes");
		if (board.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
